[hw/rtl/oets_pkg.sv]
// ============================================================================
// oets_pkg
// Shared types and constants for the odd-even transposition sorter.
// ============================================================================
`default_nettype none

package oets_pkg;

  // Default number of elements that one batch can hold.
  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  // Default depth of the queue between the front end and the sort engine.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Width of one data element.
  localparam int unsigned DATA_W = 32;

  // One classified beat as handed from the front end to the sort engine.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
    logic                     keep;
  } oets_entry_t;

  // Sort engine states, one-hot.
  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } oets_state_t;

endpackage

`default_nettype wire

[hw/rtl/oets_front.sv]
// ============================================================================
// oets_front
// Accepts input beats, tracks how many elements the current batch holds and
// marks each beat as kept or dropped before it enters the queue.
// ============================================================================
`default_nettype none

module oets_front #(
  parameter int unsigned MAX_ELEMENTS = oets_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic signed [oets_pkg::DATA_W-1:0]   in_value,
  input  wire logic                                 in_is_last,
  input  wire logic                                 q_full,
  output      logic                                 push,
  output      oets_pkg::oets_entry_t                push_entry
);
  import oets_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  logic [CW-1:0] fill_r;
  logic [CW-1:0] fill_nxt;
  logic          keep;

  // The queue alone throttles the input side.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign keep     = (fill_r < CW'(MAX_ELEMENTS));

  // Classified beat for the queue.
  always_comb begin
    push_entry.value   = in_value;
    push_entry.is_last = in_is_last;
    push_entry.keep    = keep;
  end

  // Batch fill count as seen from the input side.
  always_comb begin
    fill_nxt = fill_r;
    if (push) begin
      if (in_is_last) begin
        fill_nxt = '0;
      end else if (keep) begin
        fill_nxt = fill_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/oets_queue.sv]
// ============================================================================
// oets_queue
// Small register FIFO that decouples the front end from the sort engine.
// ============================================================================
`default_nettype none

module oets_queue #(
  parameter int unsigned DEPTH = oets_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire oets_pkg::oets_entry_t  push_entry,
  output      logic                   full,
  input  wire logic                   pop,
  output      oets_pkg::oets_entry_t  pop_entry,
  output      logic                   empty
);
  import oets_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  oets_entry_t   slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [NW-1:0] used_r;
  logic [NW-1:0] used_nxt;
  logic          do_push;
  logic          do_pop;

  assign full      = (used_r == NW'(DEPTH));
  assign empty     = (used_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slot_r[rd_ptr_r];

  // Pointer and occupancy update with explicit wrap.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    used_nxt   = used_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      used_nxt = used_r + NW'(1);
    end else if (do_pop && !do_push) begin
      used_nxt = used_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      used_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      used_r   <= used_nxt;
    end
  end

  // Storage slots carry no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/oets_back.sv]
// ============================================================================
// oets_back
// Sort engine: loads kept elements into a row of cells, runs one odd-even
// transposition phase per cycle, then shifts the row out through an output
// register.
// ============================================================================
`default_nettype none

module oets_back #(
  parameter int unsigned MAX_ELEMENTS = oets_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 q_empty,
  input  wire oets_pkg::oets_entry_t                pop_entry,
  output      logic                                 pop,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic signed [oets_pkg::DATA_W-1:0]   out_sorted_value,
  output      logic                                 out_end_of_batch,
  output      logic                                 out_overflow
);
  import oets_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  oets_state_t              state_r;
  oets_state_t              state_nxt;
  logic signed [DATA_W-1:0] cell_r   [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] cell_nxt [MAX_ELEMENTS];
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic [CW-1:0]            phase_r;
  logic [CW-1:0]            phase_nxt;
  logic                     dropped_r;
  logic                     dropped_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic signed [DATA_W-1:0] out_value_nxt;
  logic                     out_eob_r;
  logic                     out_eob_nxt;
  logic                     out_ovf_r;
  logic                     out_ovf_nxt;
  logic                     take;
  logic [CW-1:0]            count_ld;

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_batch = out_eob_r;
  assign out_overflow     = out_ovf_r;

  // The output register can take a new beat when empty or being drained.
  assign take     = !out_valid_r || !out_stall;
  assign pop      = (state_r == ST_LOAD) && !q_empty;
  assign count_ld = count_r + CW'(pop_entry.keep);

  // Control: load, sort phases, emit.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_eob_nxt   = out_eob_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (pop) begin
          count_nxt = count_ld;
          if (!pop_entry.keep) begin
            dropped_nxt = 1'b1;
          end
          if (pop_entry.is_last) begin
            phase_nxt = '0;
            if (count_ld == '0) begin
              // Nothing held: the batch produces no results.
              dropped_nxt = 1'b0;
            end else begin
              state_nxt = ST_SORT;
            end
          end
        end
      end
      ST_SORT: begin
        phase_nxt = phase_r + CW'(1);
        if (phase_r + CW'(1) == count_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (take) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = cell_r[0];
          out_eob_nxt   = (count_r == CW'(1));
          out_ovf_nxt   = dropped_r;
          count_nxt     = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            dropped_nxt = 1'b0;
            state_nxt   = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Cell row: write on load, parallel compare-exchange on sort, shift on emit.
  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    case (state_r)
      ST_LOAD: begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
          if (pop && pop_entry.keep && (count_r == CW'(i))) begin
            cell_nxt[i] = pop_entry.value;
          end
        end
      end
      ST_SORT: begin
        for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
          if ((CW'(i % 2) == CW'(phase_r[0])) && (CW'(i + 1) < count_r) &&
              (cell_r[i] > cell_r[i+1])) begin
            cell_nxt[i]   = cell_r[i+1];
            cell_nxt[i+1] = cell_r[i];
          end
        end
      end
      ST_EMIT: begin
        if (take) begin
          for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
            cell_nxt[i] = cell_r[i+1];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      phase_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_eob_r   <= out_eob_nxt;
    out_ovf_r   <= out_ovf_nxt;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

`ifndef SYNTHESIS
  // The element count never exceeds the row of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  // Emitting always has at least one element left.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (count_r != '0))
    else $error("emit state with no elements");

  // Sorting runs exactly as many phases as elements held.
  a_sort_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SORT) |-> (phase_r < count_r))
    else $error("sort phase beyond element count");

  // The last beat of a batch returns the engine to loading.
  a_eob_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && take && count_r == CW'(1)) |=> (state_r == ST_LOAD))
    else $error("engine not back to load after last beat");
`endif

endmodule

`default_nettype wire

[hw/rtl/odd_even_transposition_sort.sv]
// ============================================================================
// odd_even_transposition_sort
// Batch sorter for signed 32-bit values using odd-even transposition.
// ============================================================================
// Usage:
// The input channel (in_valid, in_stall, in_value, in_is_last) takes one
// element per beat; in_is_last closes a batch. At most MAX_ELEMENTS values
// are kept per batch; further ones are dropped and every result of that batch
// then carries out_overflow.
// The result channel (out_valid, out_stall, out_sorted_value,
// out_end_of_batch, out_overflow) gives the batch in ascending order, one
// beat per element, with out_end_of_batch on the final beat.
// Timing: a beat enters a QUEUE_DEPTH-entry queue the cycle it is accepted.
// The sort engine loads one queued element per cycle while the queue is not
// empty, then runs one transposition phase per element held (one phase of
// parallel compare-exchange per cycle), then shifts out one result per cycle
// while the output is not stalled. While the engine sorts or emits, input
// beats fill the queue and in_stall rises once it is full.
// Reset (rst_n low, synchronous) empties the queue and the batch.
// A stalled result holds its output register; the engine waits meanwhile.
// ============================================================================
`default_nettype none

module odd_even_transposition_sort #(
  parameter int unsigned MAX_ELEMENTS = oets_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned QUEUE_DEPTH  = oets_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic signed [oets_pkg::DATA_W-1:0]   in_value,
  input  wire logic                                 in_is_last,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic signed [oets_pkg::DATA_W-1:0]   out_sorted_value,
  output      logic                                 out_end_of_batch,
  output      logic                                 out_overflow
);
  import oets_pkg::*;

  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  oets_entry_t push_entry;
  oets_entry_t pop_entry;

  // Front end: accept and classify.
  oets_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .in_is_last (in_is_last),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue between front end and sort engine.
  oets_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  // Sort engine and output register.
  oets_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .pop_entry        (pop_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_end_of_batch (out_end_of_batch),
    .out_overflow     (out_overflow)
  );

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for odd_even_transposition_sort
// Sends batches of signed values, including full and over-full batches. It
// predicts the sorted beats of each batch and checks every result beat
// against them while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY   = oets_pkg::MAX_ELEMENTS_DEF;
  localparam int unsigned WIDTH      = oets_pkg::DATA_W;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          LONG_HOLD  = 600;
  localparam int          DRAIN_WAIT = 3 * CAPACITY + 40;
  localparam int          ITEM_GOAL  = 250;

  // Ways in which the receiver stalls.
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  // One expected result beat.
  typedef struct {
    logic signed [WIDTH-1:0] value;
    logic                    end_of_batch;
    logic                    overflow;
  } sorted_beat_t;

  // Keeps the batch under construction and the sorted beats still to come.
  class sort_scoreboard;
    logic signed [WIDTH-1:0] batch_values[$];
    bit                      batch_dropped;
    sorted_beat_t            sorted_pending[$];
    int                      errors;

    task report(string msg);
      $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    // Store the value while room is left, and sort the batch on its last beat.
    function void note_input(logic signed [WIDTH-1:0] value, logic is_last);
      logic signed [WIDTH-1:0] work[$];
      logic signed [WIDTH-1:0] held;
      sorted_beat_t            beat;
      int                      n;
      if (batch_values.size() < CAPACITY) batch_values.push_back(value);
      else batch_dropped = 1'b1;
      if (!is_last) return;
      work = batch_values;
      n = work.size();
      // Phase p exchanges the pairs that start at p mod 2.
      for (int phase = 0; phase < n; phase++) begin
        for (int i = phase % 2; i + 1 < n; i += 2) begin
          if (work[i] > work[i+1]) begin
            held = work[i];
            work[i] = work[i+1];
            work[i+1] = held;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        beat.value = work[k];
        beat.end_of_batch = (k == n - 1);
        beat.overflow = batch_dropped;
        sorted_pending.push_back(beat);
      end
      batch_values.delete();
      batch_dropped = 1'b0;
    endfunction

    // Compare one accepted result beat with the oldest expected one.
    task check_result(logic signed [WIDTH-1:0] value, logic eob, logic ovf);
      sorted_beat_t want;
      if (sorted_pending.size() == 0) begin
        report($sformatf("unexpected beat value=%0d eob=%b ovf=%b", value, eob, ovf));
        return;
      end
      want = sorted_pending.pop_front();
      if (value !== want.value)
        report($sformatf("sorted_value %0d, expected %0d", value, want.value));
      if (eob !== want.end_of_batch)
        report($sformatf("end_of_batch %b, expected %b (value %0d)",
                         eob, want.end_of_batch, want.value));
      if (ovf !== want.overflow)
        report($sformatf("overflow %b, expected %b (value %0d)",
                         ovf, want.overflow, want.value));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [WIDTH-1:0] in_value = '0;
  logic                    in_is_last = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [WIDTH-1:0] out_sorted_value;
  logic                    out_end_of_batch;
  logic                    out_overflow;

  sort_scoreboard sb = new;
  int             burst_left = 0;
  int             items_sent = 0;
  int             idle_cycles = 0;
  bit             hold_request = 1'b0;

  odd_even_transposition_sort dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_end_of_batch (out_end_of_batch),
    .out_overflow     (out_overflow)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Offer one beat, idling first when the current burst is used up.
  task send_beat(logic signed [WIDTH-1:0] value, logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
    end
    in_valid   <= 1'b1;
    in_value   <= value;
    in_is_last <= is_last;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
    sb.note_input(value, is_last);
  endtask

  // Extremes, values near zero so that duplicates occur, and random words.
  function automatic logic signed [WIDTH-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      4, 5:    return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: directed batches, then random batches.
  initial begin
    int size;
    int batch_no;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-element batches at both extremes and at zero.
    send_beat(32'sh8000_0000, 1'b1);
    send_beat(32'sh7fff_ffff, 1'b1);
    send_beat('0, 1'b1);
    // Extremes mixed in one batch.
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(-1, 1'b0);
    send_beat('0, 1'b0);
    send_beat(1, 1'b1);
    // Equal values stay in place.
    send_beat(5, 1'b0);
    send_beat(5, 1'b0);
    send_beat(5, 1'b1);
    // Strictly descending batch.
    for (int v = 4; v >= -1; v--) send_beat(v, v == -1);

    // Random batches: mostly small, one full, one over-full whose extra beats, the last included, are dropped.
    batch_no = 0;
    while (items_sent < ITEM_GOAL) begin
      if (batch_no == 4) begin
        size = CAPACITY;
        hold_request = 1'b1;
      end else if (batch_no == 9) begin
        size = CAPACITY + $urandom_range(1, 3);
      end else if ($urandom_range(0, 7) == 0) begin
        size = $urandom_range(13, 24);
      end else begin
        size = $urandom_range(1, 12);
      end
      for (int k = 0; k < size; k++) send_beat(pick_value(), k == size - 1);
      batch_no++;
    end
    in_valid <= 1'b0;

    // Drain, then allow for any stray beats.
    while (sb.sorted_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Receiver: checks accepted beats and stalls on a pattern of its own, with one
  // long hold-off during the full batch so that the input side backs up.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    bit       hold_done;
    mode = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_sorted_value, out_end_of_batch, out_overflow);
      if (hold_request && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          RX_TOGGLE: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Watchdog: ends the run after too many cycles without a beat on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end
endmodule
